### src/stereo_ssd_block_matcher_unit_macros.svh
// assertion macros for the stereo ssd block matcher
`ifndef STEREO_SSD_BLOCK_MATCHER_UNIT_MACROS_SVH
`define STEREO_SSD_BLOCK_MATCHER_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define SSDBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition that holds at every enabled edge
`define SSDBM_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

### src/ssdbm_pkg.sv
// shared constants, types and helpers of the stereo ssd block matcher
package ssdbm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_HALF   = 3;
  localparam int MAX_DISP   = 32;
  localparam int LINES      = 2 * MAX_HALF + 1;
  localparam int MAX_RES    = MAX_HALF + MAX_DISP;

  localparam int PIX_W   = 8;
  localparam int DIM_W   = 11;
  localparam int HALF_W  = 2;
  localparam int DISP_W  = 5;
  localparam int COST_W  = 16;
  localparam int VIS_W   = 8;
  localparam int COL_W   = 10;
  localparam int SLOT_W  = 3;
  localparam int ADDR_W  = SLOT_W + COL_W;
  localparam int DEPTH   = LINES * MAX_WIDTH;
  localparam int ACC_W   = 22;
  localparam int NUM_W   = 13;
  localparam int N_W     = 6;
  localparam int CIDX_W  = 3;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [DISP_W-1:0] disp_t;
  typedef logic [COST_W-1:0] cost_t;
  typedef logic [VIS_W-1:0]  vis_t;
  typedef logic [ACC_W-1:0]  acc_t;

  localparam logic [CIDX_W-1:0] CFG_WIDTH  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_HALF   = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_DLOW   = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_DHIGH  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_FILL, ST_DRAIN, ST_SCAN, ST_VIS, ST_DIVW, ST_OUT
  } state_t;

  typedef struct packed {
    logic shift_pix;
    logic acc_en;
    logic clr;
    logic shift_cost;
  } cell_ctl_t;

  function automatic logic [SLOT_W-1:0] mod_lines(input logic [4:0] v);
    logic [4:0] t;
    t = v;
    if (t >= 5'(2 * LINES)) t = t - 5'(2 * LINES);
    else if (t >= 5'(LINES)) t = t - 5'(LINES);
    return t[SLOT_W-1:0];
  endfunction

endpackage

### src/ssdbm_in_if.sv
// input pixel pair channel
interface ssdbm_in_if;
  import ssdbm_pkg::*;
  logic valid;
  logic ready;
  pix_t left_pixel;
  pix_t right_pixel;
  logic frame_start;
  modport source(output valid, left_pixel, right_pixel, frame_start, input ready);
  modport sink(input valid, left_pixel, right_pixel, frame_start, output ready);
endinterface

### src/ssdbm_out_if.sv
// result channel
interface ssdbm_out_if;
  import ssdbm_pkg::*;
  logic  valid;
  logic  ready;
  disp_t disparity;
  cost_t match_cost;
  vis_t  visual_level;
  logic  row_end;
  logic  frame_end;
  modport source(output valid, disparity, match_cost, visual_level, row_end, frame_end,
                 input ready);
  modport sink(input valid, disparity, match_cost, visual_level, row_end, frame_end,
               output ready);
endinterface

### src/ssdbm_cfg_if.sv
// configuration write channel
interface ssdbm_cfg_if;
  import ssdbm_pkg::*;
  logic              valid;
  logic              ready;
  logic [CIDX_W-1:0] index;
  dim_t              data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### src/ssdbm_cell.sv
// one disparity cell: right pixel tap plus ssd accumulator
module ssdbm_cell (
  input  logic                  clk,
  input  ssdbm_pkg::cell_ctl_t  ctl,
  input  ssdbm_pkg::pix_t       left_pix,
  input  ssdbm_pkg::pix_t       right_in,
  output ssdbm_pkg::pix_t       right_out,
  input  ssdbm_pkg::acc_t       cost_in,
  output ssdbm_pkg::acc_t       cost_out
);
  import ssdbm_pkg::*;

  pix_t        right_r;
  acc_t        acc_r;
  logic signed [PIX_W:0]       diff;
  logic        [2*PIX_W-1:0]   sq;
  logic signed [2*PIX_W+1:0]   prod;

  assign diff = $signed({1'b0, left_pix}) - $signed({1'b0, right_in});
  assign prod = diff * diff;
  assign sq   = prod[2*PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.shift_pix) right_r <= right_in;
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (ctl.shift_cost) begin
      acc_r <= cost_in;
    end else if (ctl.acc_en) begin
      acc_r <= acc_r + ACC_W'(sq);
    end
  end

  assign right_out = right_r;
  assign cost_out  = acc_r;
endmodule

### src/ssdbm_div.sv
// restoring divider, one quotient bit per cycle
module ssdbm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ssdbm_pkg::NUM_W-1:0]   num,
  input  ssdbm_pkg::disp_t              den,
  output logic                          done,
  output logic [ssdbm_pkg::NUM_W-1:0]   quo
);
  import ssdbm_pkg::*;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] sh_r;
  disp_t            rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [DISP_W:0]  trial;
  logic             ge;

  assign trial = {rem_r, sh_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        sh_r   <= num;
        rem_r  <= '0;
        cnt_r  <= CNT_W'(NUM_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? DISP_W'(trial - {1'b0, den}) : trial[DISP_W-1:0];
        sh_r  <= {sh_r[NUM_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = sh_r;
endmodule

### src/stereo_ssd_block_matcher_unit.sv
// top level of the stereo ssd block matcher
//
//  channel  dir  beat contents
//  in_ch    in   left_pixel, right_pixel, frame_start
//  out_ch   out  disparity, match_cost, visual_level, row_end, frame_end
//  cfg_ch   in   index, data (always ready)
//
// after each pixel beat, every result waits on the visual divider, and
// a result for a matched column also waits on the window sweep through
// the single read port of each line memory feeding the disparity cell chain.
// reset is synchronous active low; line memories are not cleared.
// a stalled out_ch holds the sequencer once the next result is ready.
`include "stereo_ssd_block_matcher_unit_macros.svh"
module stereo_ssd_block_matcher_unit (
  input logic        clk,
  input logic        rst_n,
  ssdbm_in_if.sink   in_ch,
  ssdbm_out_if.source out_ch,
  ssdbm_cfg_if.sink  cfg_ch
);
  import ssdbm_pkg::*;

  dim_t              cfg_w_r, cfg_h_r;
  logic [HALF_W-1:0] half_r;
  disp_t             lo_r, hi_r;

  state_t state_r, state_nxt;
  logic [COL_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  dim_t              emit_r, emit_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              last_r, last_nxt, act_r, act_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [5:0]        s_r, s_nxt;
  disp_t             dd_r, dd_nxt;
  logic [11:0]       base_r, base_nxt;
  cost_t             best_r, best_nxt;
  disp_t             bestd_r, bestd_nxt;
  logic              rl_r, rl_nxt, fe_r, fe_nxt, vneg_r, vneg_nxt;
  logic              pipe_v_r, pipe_v_nxt, pipe_a_r, pipe_a_nxt;
  logic              out_valid_r, out_load;
  disp_t             o_disp_r;
  cost_t             o_cost_r;
  vis_t              o_vis_r;
  logic              o_re_r, o_fe_r;

  dim_t w_eff, ht_eff;
  logic [2:0] h2;
  logic [5:0] lag, s_end;
  logic in_acc;

  assign w_eff  = (cfg_w_r == '0) ? DIM_W'(1) :
                  (cfg_w_r > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : cfg_w_r;
  assign ht_eff = (cfg_h_r == '0) ? DIM_W'(1) :
                  (cfg_h_r > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : cfg_h_r;
  assign h2     = {half_r, 1'b0};
  assign lag    = 6'(half_r) + 6'(hi_r);
  assign s_end  = 6'(hi_r) + 6'(h2);

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= DIM_W'(640);
      cfg_h_r <= DIM_W'(480);
      half_r  <= HALF_W'(2);
      lo_r    <= '0;
      hi_r    <= DISP_W'(31);
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_WIDTH:  cfg_w_r <= cfg_ch.data;
        CFG_HEIGHT: cfg_h_r <= cfg_ch.data;
        CFG_HALF:   half_r  <= cfg_ch.data[HALF_W-1:0];
        CFG_DLOW:   lo_r    <= cfg_ch.data[DISP_W-1:0];
        CFG_DHIGH:  hi_r    <= cfg_ch.data[DISP_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;

  // effective position of the accepted beat
  dim_t row_a, col_a, emit_a;
  logic [SLOT_W-1:0] slot_a;
  always_comb begin
    row_a  = in_ch.frame_start ? '0 : DIM_W'(row_r);
    col_a  = in_ch.frame_start ? '0 : DIM_W'(col_r);
    emit_a = in_ch.frame_start ? '0 : emit_r;
    slot_a = in_ch.frame_start ? '0 : slot_r;
    if (col_a >= w_eff) begin
      col_a  = '0;
      emit_a = '0;
      row_a  = row_a + DIM_W'(1);
      slot_a = (slot_a == SLOT_W'(LINES - 1)) ? '0 : slot_a + SLOT_W'(1);
    end
    if (row_a >= ht_eff) begin
      row_a  = '0;
      slot_a = '0;
    end
  end

  // line memories
  pix_t left_mem [0:DEPTH-1];
  pix_t right_mem [0:DEPTH-1];
  pix_t l_q, r_q;
  logic [ADDR_W-1:0] wr_addr, rd_addr_l, rd_addr_r;
  logic [SLOT_W-1:0] win_slot;
  logic [11:0] col_raw;
  logic [COL_W-1:0] rcol;
  logic rd_en;

  assign wr_addr  = {slot_a, col_a[COL_W-1:0]};
  assign win_slot = mod_lines(5'(slot_r) + 5'(LINES) - 5'(h2) + 5'(k_r));
  assign col_raw  = base_r - 12'(s_r);
  assign rcol     = (col_raw > 12'(w_eff - DIM_W'(1))) ? COL_W'(w_eff - DIM_W'(1)) :
                    col_raw[COL_W-1:0];
  assign rd_addr_l = {win_slot, col_raw[COL_W-1:0]};
  assign rd_addr_r = {win_slot, rcol};
  assign rd_en     = (state_r == ST_FILL);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_mem[wr_addr]  <= in_ch.left_pixel;
      right_mem[wr_addr] <= in_ch.right_pixel;
    end
    if (rd_en) begin
      l_q <= left_mem[rd_addr_l];
      r_q <= right_mem[rd_addr_r];
    end
  end

  // disparity cell chain
  cell_ctl_t ctl;
  logic clr_c, shift_cost_c;
  pix_t right_link [MAX_DISP];
  acc_t acc_link [MAX_DISP];

  assign ctl.shift_pix  = pipe_v_r;
  assign ctl.acc_en     = pipe_a_r;
  assign ctl.clr        = clr_c;
  assign ctl.shift_cost = shift_cost_c;

  for (genvar t = 0; t < MAX_DISP; t++) begin : g_cell
    pix_t rin;
    acc_t cin;
    if (t == 0) begin : g_head
      assign rin = r_q;
    end else begin : g_mid
      assign rin = right_link[t-1];
    end
    if (t == MAX_DISP - 1) begin : g_tail
      assign cin = '0;
    end else begin : g_body
      assign cin = acc_link[t+1];
    end
    ssdbm_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .left_pix (l_q),
      .right_in (rin),
      .right_out(right_link[t]),
      .cost_in  (cin),
      .cost_out (acc_link[t])
    );
  end

  // visual level divider
  logic div_start, div_done;
  logic [NUM_W-1:0] div_num, div_q;
  disp_t div_den, dmag;
  vis_t vis_val;

  assign dmag    = (bestd_r >= lo_r) ? bestd_r - lo_r : lo_r - bestd_r;
  assign div_num = NUM_W'(dmag) * NUM_W'(192);
  assign div_den = (hi_r >= lo_r) ? hi_r - lo_r : lo_r - hi_r;
  assign vis_val = (hi_r == lo_r) ? VIS_W'(63) :
                   vneg_r ? VIS_W'(63) - div_q[VIS_W-1:0] : VIS_W'(63) + div_q[VIS_W-1:0];

  ssdbm_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_q)
  );

  // column sequencer
  logic emit_ok, interior, res_last;
  assign emit_ok  = act_r && (n_r < N_W'(MAX_RES)) && (emit_r < w_eff) &&
                    (last_r || (12'(emit_r) + 12'(lag) <= 12'(col_r)));
  assign interior = (emit_r >= DIM_W'(half_r)) && (emit_r + DIM_W'(half_r) < w_eff);
  assign res_last = last_r && !(((n_r + N_W'(1)) < N_W'(MAX_RES)) &&
                                ((emit_r + DIM_W'(1)) < w_eff));

  dim_t row_inc;
  assign row_inc = DIM_W'(row_r) + DIM_W'(1);

  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r; col_nxt = col_r; emit_nxt = emit_r; slot_nxt = slot_r;
    last_nxt = last_r; act_nxt = act_r; n_nxt = n_r; k_nxt = k_r; s_nxt = s_r;
    dd_nxt = dd_r; base_nxt = base_r; best_nxt = best_r; bestd_nxt = bestd_r;
    rl_nxt = rl_r; fe_nxt = fe_r; vneg_nxt = vneg_r;
    pipe_v_nxt = 1'b0; pipe_a_nxt = 1'b0;
    clr_c = 1'b0; shift_cost_c = 1'b0; div_start = 1'b0; out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          row_nxt   = row_a[COL_W-1:0];
          col_nxt   = col_a[COL_W-1:0];
          emit_nxt  = emit_a;
          slot_nxt  = slot_a;
          last_nxt  = (col_a == w_eff - DIM_W'(1));
          act_nxt   = (row_a >= DIM_W'(h2));
          n_nxt     = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (emit_ok) begin
          rl_nxt    = res_last;
          fe_nxt    = res_last && (DIM_W'(row_r) == ht_eff - DIM_W'(1));
          best_nxt  = '1;
          bestd_nxt = '0;
          if (interior) begin
            k_nxt     = '0;
            s_nxt     = '0;
            base_nxt  = 12'(emit_r) + 12'(half_r) + 12'(hi_r);
            clr_c     = 1'b1;
            state_nxt = ST_FILL;
          end else begin
            state_nxt = ST_VIS;
          end
        end else begin
          if (last_r) begin
            col_nxt  = '0;
            emit_nxt = '0;
            if (row_inc >= ht_eff) begin
              row_nxt  = '0;
              slot_nxt = '0;
            end else begin
              row_nxt  = row_inc[COL_W-1:0];
              slot_nxt = (slot_r == SLOT_W'(LINES - 1)) ? '0 : slot_r + SLOT_W'(1);
            end
          end else begin
            col_nxt = col_r + COL_W'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_FILL: begin
        pipe_v_nxt = 1'b1;
        pipe_a_nxt = (s_r >= 6'(hi_r));
        if (s_r == s_end) begin
          s_nxt = '0;
          if (k_r == h2) state_nxt = ST_DRAIN;
          else k_nxt = k_r + 3'd1;
        end else begin
          s_nxt = s_r + 6'd1;
        end
      end
      ST_DRAIN: begin
        dd_nxt    = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        shift_cost_c = 1'b1;
        if (dd_r >= lo_r && acc_link[0] < ACC_W'(best_r)) begin
          best_nxt  = acc_link[0][COST_W-1:0];
          bestd_nxt = dd_r;
        end
        if (dd_r == hi_r) state_nxt = ST_VIS;
        else dd_nxt = dd_r + DISP_W'(1);
      end
      ST_VIS: begin
        div_start = 1'b1;
        vneg_nxt  = (bestd_r < lo_r) ^ (hi_r < lo_r);
        state_nxt = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          emit_nxt  = emit_r + DIM_W'(1);
          n_nxt     = n_r + N_W'(1);
          state_nxt = ST_CHECK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      row_r <= '0; col_r <= '0; emit_r <= '0; slot_r <= '0;
      last_r <= 1'b0; act_r <= 1'b0; n_r <= '0; k_r <= '0; s_r <= '0; dd_r <= '0;
      pipe_v_r <= 1'b0; pipe_a_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_r <= row_nxt; col_r <= col_nxt; emit_r <= emit_nxt; slot_r <= slot_nxt;
      last_r <= last_nxt; act_r <= act_nxt; n_r <= n_nxt; k_r <= k_nxt; s_r <= s_nxt;
      dd_r <= dd_nxt;
      pipe_v_r <= pipe_v_nxt; pipe_a_r <= pipe_a_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt; best_r <= best_nxt; bestd_r <= bestd_nxt;
    rl_r <= rl_nxt; fe_r <= fe_nxt; vneg_r <= vneg_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_disp_r <= bestd_r;
      o_cost_r <= best_r;
      o_vis_r  <= vis_val;
      o_re_r   <= rl_r;
      o_fe_r   <= fe_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.disparity    = o_disp_r;
  assign out_ch.match_cost   = o_cost_r;
  assign out_ch.visual_level = o_vis_r;
  assign out_ch.row_end      = o_re_r;
  assign out_ch.frame_end    = o_fe_r;

  `SSDBM_ASSERT_NOW(a_load_from_out, $rose(out_valid_r), $past(state_r) == ST_OUT, "result loaded outside output state")
  `SSDBM_ASSERT_NOW(a_div_wait, div_done, state_r == ST_DIVW, "divider finished while not awaited")
  `SSDBM_ASSERT_ALWAYS(a_res_cap, n_r <= N_W'(MAX_RES), "too many results for one beat")
  `SSDBM_ASSERT_NOW(a_emit_range, state_r == ST_OUT, emit_r < w_eff, "result column beyond row")

endmodule
